>>> rtl/kqt_pkg.sv
// shared types and constants of the keyed quantity table
package kqt_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = 6;
   localparam int CMP_W    = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
   localparam int TOTAL_W  = 7;

   typedef struct packed {
      logic signed [31:0] quantity;
      logic [15:0]        brand;
      logic [15:0]        part;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_SET   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

>>> rtl/kqt_cell.sv
// one storage cell of the entry ring, shifting toward the head
module kqt_cell
   import kqt_pkg::*;
(
   input  logic      clock,
   input  logic      shift_en,
   input  entry_type entry_in,
   output entry_type entry_out
);

   entry_type entry_ff;
   entry_type entry_in_next;

   always_comb begin
      entry_in_next = shift_en ? entry_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in_next;
   end

   assign entry_out = entry_ff;

endmodule

>>> rtl/keyed_quantity_table.sv
// top level of the keyed quantity table: ring of entry cells and its sequencer
//
// The table holds up to CAPACITY entries (part key, brand key, signed quantity) in a ring
// of cells that rotates by one cell each cycle, while a sweep is running, past a single
// compare and write-back point at the head. A query, a read, an update or an append sweeps
// the ring once; a delete of a present key needs a second sweep to move the last entry
// into the freed slot. Mode 3 does nothing and answers with the entry count. One request
// is worked on at a time; the result sits in an output register, so the next request is
// taken while it waits. There is no clearing pass after reset: only slots below the
// entry count are ever read.
module keyed_quantity_table
   import kqt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // part_key[15:0], brand_key[31:16], new_quantity[63:32], entry_index[69:64], zero pad
   input  logic [71:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], found[1], out_part[17:2], out_brand[33:18], out_quantity[65:34],
   // entry_total[72:66], zero pad
   output logic [79:0] rsp_tdata
);

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   entry_type         last_ff, last_in;
   entry_type         hold_ff, hold_in;
   mode_type          mode_ff;
   logic [15:0]       part_ff, brand_ff;
   logic signed [31:0] qty_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [79:0]       rsp_data_ff, rsp_data_in;

   entry_type chain [CAPACITY];
   entry_type head;
   entry_type wb;
   logic      shift_en;

   logic             req_fire;
   logic             slot_last;
   logic [CNT_W-1:0] slot_ext;
   logic             in_range;
   logic             key_hit;
   logic             positive;
   logic             load;
   logic             append;
   logic             out_ok;
   logic             out_found;
   entry_type        out_entry;

   // ring of cells, slot k reaches the head when the sweep's slot counter equals k
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type cell_in;
      if (i == CAPACITY - 1) begin : g_tail
         assign cell_in = wb;
      end else begin : g_mid
         assign cell_in = chain[i+1];
      end
      kqt_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .entry_in  (cell_in),
         .entry_out (chain[i])
      );
   end

   assign head       = chain[0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign shift_en   = (state_ff == ST_SEARCH) || (state_ff == ST_MOVE);
   assign slot_last  = (slot_ff == SLOT_W'(CAPACITY - 1));
   assign slot_ext   = CNT_W'(slot_ff);
   assign in_range   = slot_ext < count_ff;
   assign key_hit    = in_range && !found_ff && (head.part == part_ff) &&
                       (head.brand == brand_ff);
   assign positive   = !qty_ff[31] && (qty_ff != 32'sd0);
   assign load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == MODE_SET || req_tuser == MODE_QUERY ||
                   req_tuser == MODE_READ) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            if (slot_last) begin
               if (mode_ff == MODE_SET && !positive && found_in) begin
                  state_in = ST_MOVE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOVE: begin
            if (slot_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // head cell compare and write-back
   always_comb begin
      wb       = head;
      found_in = found_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      hold_in  = hold_ff;
      slot_in  = slot_ff;
      if (shift_en) begin
         slot_in = slot_last ? '0 : slot_ff + SLOT_W'(1);
      end
      if (req_fire) begin
         found_in = 1'b0;
      end else if (state_ff == ST_SEARCH) begin
         case (mode_ff)
            MODE_SET: begin
               if (positive) begin
                  if (key_hit) begin
                     wb.quantity = qty_ff;
                     found_in    = 1'b1;
                  end else if (!found_ff && slot_ext == count_ff) begin
                     // first free slot: append
                     wb.part     = part_ff;
                     wb.brand    = brand_ff;
                     wb.quantity = qty_ff;
                  end
               end else begin
                  if (key_hit) begin
                     pos_in   = slot_ff;
                     found_in = 1'b1;
                  end
                  if (slot_ext + CNT_W'(1) == count_ff) begin
                     last_in = head;
                  end
               end
            end
            MODE_QUERY: begin
               if (key_hit) begin
                  hold_in  = head;
                  found_in = 1'b1;
               end
            end
            MODE_READ: begin
               if (in_range && CMP_W'(slot_ff) == CMP_W'(idx_ff)) begin
                  hold_in  = head;
                  found_in = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (state_ff == ST_MOVE) begin
         if (slot_ff == pos_ff) begin
            wb = last_ff;
         end
      end
   end

   // result and entry count
   always_comb begin
      append    = (mode_ff == MODE_SET) && positive && !found_ff;
      out_ok    = (mode_ff == MODE_SET) && !(append && count_ff == CNT_W'(CAPACITY));
      out_found = ((mode_ff == MODE_QUERY) || (mode_ff == MODE_READ)) && found_ff;
      out_entry = out_found ? hold_ff : '0;
      count_in  = count_ff;
      if (load) begin
         if (append && count_ff != CNT_W'(CAPACITY)) begin
            count_in = count_ff + CNT_W'(1);
         end else if (mode_ff == MODE_SET && !positive && found_ff) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      rsp_data_in  = load ? {7'd0, TOTAL_W'(count_in), out_entry.quantity,
                             out_entry.brand, out_entry.part, out_found, out_ok}
                          : rsp_data_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         mode_ff  <= mode_type'(req_tuser);
         part_ff  <= req_tdata[15:0];
         brand_ff <= req_tdata[31:16];
         qty_ff   <= req_tdata[63:32];
         idx_ff   <= req_tdata[69:64];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && slot_last) |=> (state_ff != ST_SEARCH))
      else $error("search sweep did not end after one turn of the ring");

   a_count_only_at_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> $stable(count_ff))
      else $error("entry count changed outside result load");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised without a finished request");

   a_ok_found_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("ok and found both set");
`endif

endmodule

>>> tb/tb_keyed_quantity_table.sv
// self-checking testbench for the keyed quantity table: directed and random stock requests against a predictor
module tb_keyed_quantity_table;
   import kqt_pkg::*;

   localparam logic [1:0] MODE_NONE = 2'd3;  // unused mode, answers with the count only
   localparam int KEY_POOL    = 80;          // more keys than slots so the table fills up
   localparam int RANDOM_REQS = 1200;
   localparam int PHASE_LEN   = 200;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 10;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        part;
      logic [15:0]        brand;
      logic signed [31:0] qty;
      logic [5:0]         index;
   } stock_request;

   typedef struct packed {
      logic               ok;
      logic               found;
      logic [15:0]        part;
      logic [15:0]        brand;
      logic signed [31:0] qty;
      logic [6:0]         total;
   } stock_reply;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   keyed_quantity_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   stock_request pending_requests[$];
   stock_reply   expected_replies[$];
   int           errors = 0;

   // predicted inventory
   entry_type   shelf[CAPACITY];
   int unsigned shelf_count = 0;
   int          n_requests = 0, n_appends = 0, n_updates = 0, n_moves = 0;
   int          n_full = 0, n_hits = 0, n_reads = 0, peak_fill = 0;

   function automatic stock_reply apply_stock_request(stock_request r);
      stock_reply  y;
      int unsigned pos;
      y   = '0;
      pos = shelf_count;
      for (int unsigned i = 0; i < shelf_count; i++) begin
         if (pos == shelf_count && shelf[i].part == r.part && shelf[i].brand == r.brand)
            pos = i;
      end
      n_requests++;
      case (r.mode)
         MODE_SET: begin
            y.ok = 1'b1;
            if (r.qty <= 0) begin
               if (pos < shelf_count) begin
                  shelf[pos] = shelf[shelf_count - 1];
                  shelf_count--;
                  n_moves++;
               end
            end else if (pos < shelf_count) begin
               shelf[pos].quantity = r.qty;
               n_updates++;
            end else if (shelf_count >= CAPACITY) begin
               y.ok = 1'b0;
               n_full++;
            end else begin
               shelf[shelf_count] = '{quantity: r.qty, brand: r.brand, part: r.part};
               shelf_count++;
               n_appends++;
            end
         end
         MODE_QUERY, MODE_READ: begin
            if (r.mode == MODE_READ)
               pos = 32'(r.index);
            if (pos < shelf_count) begin
               y.found = 1'b1;
               y.part  = shelf[pos].part;
               y.brand = shelf[pos].brand;
               y.qty   = shelf[pos].quantity;
               if (r.mode == MODE_QUERY)
                  n_hits++;
               else
                  n_reads++;
            end
         end
         default: ;
      endcase
      if (shelf_count > peak_fill)
         peak_fill = shelf_count;
      y.total = shelf_count[6:0];
      return y;
   endfunction

   function automatic stock_request make_req(logic [1:0] mode, logic [15:0] part,
                                             logic [15:0] brand, logic [31:0] qty,
                                             logic [5:0] index);
      stock_request r;
      r.mode  = mode;
      r.part  = part;
      r.brand = brand;
      r.qty   = qty;
      r.index = index;
      return r;
   endfunction

   function automatic logic [31:0] positive_qty();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'd1;
         1: v = 32'h7fff_ffff;
         default: begin
            v = $urandom & 32'h7fff_ffff;
            if (v == 0)
               v = 32'd1;
         end
      endcase
      return v;
   endfunction

   function automatic logic [31:0] removal_qty();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   // mostly short gaps, now and then a long one; none at all while steady
   function automatic int pick_pause(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int pause_left = 0;
   bit req_steady = 1'b0;

   always @(posedge clock) begin
      stock_request it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pause_left > 0) begin
            pause_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            it = pending_requests.pop_front();
            req_tdata  <= {2'b00, it.index, it.qty, it.brand, it.part};
            req_tuser  <= it.mode;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 49) == 0)
               req_steady = ~req_steady;
            pause_left = pick_pause(req_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: result check, prediction of accepted beats, receiver stalls, watchdog
   int stall_left = 0;
   bit rsp_steady = 1'b0;
   int idle_cycles = 0;

   always @(posedge clock) begin
      stock_reply exp, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            got.ok    = rsp_tdata[0];
            got.found = rsp_tdata[1];
            got.part  = rsp_tdata[17:2];
            got.brand = rsp_tdata[33:18];
            got.qty   = rsp_tdata[65:34];
            got.total = rsp_tdata[72:66];
            if (expected_replies.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result beat %h", $realtime, rsp_tdata);
            end else begin
               exp = expected_replies.pop_front();
               if (got.ok !== exp.ok || got.found !== exp.found || got.part !== exp.part ||
                   got.brand !== exp.brand || got.qty !== exp.qty || got.total !== exp.total)
               begin
                  errors++;
                  if (errors <= 10) begin
                     $write("%0t: mismatch ok %b/%b found %b/%b part %h/%h brand %h/%h",
                            $realtime, exp.ok, got.ok, exp.found, got.found,
                            exp.part, got.part, exp.brand, got.brand);
                     $display(" qty %0d/%0d total %0d/%0d (expected/actual)",
                              exp.qty, got.qty, exp.total, got.total);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            expected_replies.push_back(apply_stock_request(
               make_req(req_tuser, req_tdata[15:0], req_tdata[31:16],
                        req_tdata[63:32], req_tdata[69:64])));
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) == 0)
               rsp_steady = ~rsp_steady;
            if (!rsp_steady && $urandom_range(0, 7) == 0)
               stall_left = pick_pause(1'b0);
            rsp_tready <= (stall_left == 0);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   logic [15:0] pool_part[KEY_POOL];
   logic [15:0] pool_brand[KEY_POOL];

   initial begin
      int          k, r;
      bit          growing;
      logic [1:0]  m;
      logic [15:0] p, b;

      // key pool: some keys share a part or a brand with their neighbor
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_part[i]  = 16'($urandom_range(0, 65535));
         pool_brand[i] = 16'($urandom_range(0, 65535));
         if (i % 4 == 1)
            pool_part[i] = pool_part[i - 1];
         if (i % 4 == 2)
            pool_brand[i] = pool_brand[i - 1];
      end

      // directed: empty table, key extremes, update, deletes, unused mode
      pending_requests.push_back(make_req(MODE_QUERY, 16'h0000, 16'h0000, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'hffff, 16'hffff, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'h0000, 16'h0000, 32'd1, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'hffff, 16'hffff, 32'h7fff_ffff, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'hffff, 16'h0000, 32'd5, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'h0000, 16'hffff, 32'd7, 6'd0));
      pending_requests.push_back(make_req(MODE_QUERY, 16'hffff, 16'hffff, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'hffff, 16'hffff, 32'h1234_5678, 6'd63));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd63));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd1));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd4));
      // removing slot 0 pulls the last entry forward
      pending_requests.push_back(make_req(MODE_SET, 16'h0000, 16'h0000, 32'h8000_0000, 6'd0));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd0));
      // removing the last slot copies it onto itself
      pending_requests.push_back(make_req(MODE_SET, 16'hffff, 16'h0000, 32'hffff_ffff, 6'd0));
      pending_requests.push_back(make_req(MODE_READ, 16'h0000, 16'h0000, 32'd0, 6'd2));
      pending_requests.push_back(make_req(MODE_QUERY, 16'h0000, 16'h0000, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_SET, 16'h1234, 16'h5678, 32'hffff_fffe, 6'd0));
      pending_requests.push_back(make_req(MODE_NONE, 16'hffff, 16'hffff, 32'hffff_ffff, 6'd63));
      pending_requests.push_back(make_req(MODE_NONE, 16'h0000, 16'h0000, 32'd0, 6'd0));
      pending_requests.push_back(make_req(MODE_QUERY, 16'h0000, 16'hffff, 32'd0, 6'd0));

      // random: alternating fill and drain phases over the key pool, a little noise
      for (int n = 0; n < RANDOM_REQS; n++) begin
         growing = ((n / PHASE_LEN) % 2 == 0);
         k = $urandom_range(0, KEY_POOL - 1);
         p = pool_part[k];
         b = pool_brand[k];
         r = $urandom_range(0, 99);
         if (r >= 94) begin
            p = 16'($urandom_range(0, 65535));
            b = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
         end
         if (r < (growing ? 55 : 20))
            pending_requests.push_back(make_req(MODE_SET, p, b, positive_qty(),
                                                6'($urandom_range(0, 63))));
         else if (r < (growing ? 63 : 55))
            pending_requests.push_back(make_req(MODE_SET, p, b, removal_qty(),
                                                6'($urandom_range(0, 63))));
         else begin
            if (r < 78)
               m = MODE_QUERY;
            else if (r < 97)
               m = MODE_READ;
            else
               m = MODE_NONE;
            pending_requests.push_back(make_req(m, p, b, $urandom,
                                                6'($urandom_range(0, 63))));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid)
         @(negedge clock);
      while (expected_replies.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d requests: %0d appends, %0d updates, %0d removals, %0d rejected as full",
               n_requests, n_appends, n_updates, n_moves, n_full);
      $display("%0d query hits, %0d reads in range, table peaked at %0d of %0d entries",
               n_hits, n_reads, peak_fill, CAPACITY);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> keyed_quantity_table.f
rtl/kqt_pkg.sv
rtl/kqt_cell.sv
rtl/keyed_quantity_table.sv
tb/tb_keyed_quantity_table.sv
